/* src/kpls_pkg.sv */
// ----------------------------------------------------------------------------
// kpls_pkg: shared types and constants of the k-mer pair last-seen map
// Holds the channel payload types, the status and operation codes, the
// configuration register indexes and the hash multiplier.
// ----------------------------------------------------------------------------
package kpls_pkg;

  localparam int ID_W      = 32;
  localparam int BASE_W    = 2;
  localparam int BLOCK_W   = 6;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;

  // Base counter saturates here; positions at or above it are never collected.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Multiplicative hash constant (golden ratio, 64 bits).
  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  // Request operations.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FIRST = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SEEN  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLOCK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BLOCK = 2'd1;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   read_id;
    logic [BASE_W-1:0] base;
    logic              last;
  } kpls_in_t;

  typedef struct packed {
    logic [ID_W-1:0]     link_id;
    logic [STATUS_W-1:0] status;
  } kpls_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [BLOCK_W-1:0]   data;
  } kpls_cfg_t;

  // Status of the slot hash unit as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } kpls_hash_stat_t;

endpackage

/* src/kpls_stream_if.sv */
// ----------------------------------------------------------------------------
// kpls_stream_if: valid/ready channel
// Carries one payload per request; a request moves at a rising clock edge
// where valid and ready are both high.
// ----------------------------------------------------------------------------
interface kpls_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/kpls_slot_hash.sv */
// ----------------------------------------------------------------------------
// kpls_slot_hash: multi-cycle slot hash unit
// Multiplies the combined key by the 64-bit hash constant modulo 2^64 with one
// shared 32x32 multiplier, then reduces the upper product word modulo the
// table size four bits per cycle.
// ----------------------------------------------------------------------------
module kpls_slot_hash #(
  parameter int COMBO_W       = 32,
  parameter int TABLE_ENTRIES = 4096,
  localparam int SLOT_W       = $clog2(TABLE_ENTRIES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COMBO_W-1:0]       key_i,
  output kpls_pkg::kpls_hash_stat_t stat_o,
  output logic [SLOT_W-1:0]        slot_o
);
  import kpls_pkg::*;

  localparam int REM_W = SLOT_W + 1;
  localparam logic [REM_W-1:0] MOD_N = REM_W'(TABLE_ENTRIES);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL  = 2'd1;
  localparam logic [1:0] H_MOD  = 2'd2;
  localparam logic [1:0] H_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [3:0]        step_q;
  logic [63:0]       key_ext;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       prod_q;
  logic [31:0]       acc_q;
  logic [SLOT_W-1:0] rem_q, rem_next;

  // Operand selection for the shared multiplier: lo*lo, lo*hi, hi*lo.
  assign key_ext = 64'(key_i);
  assign mul_a   = (step_q == 4'd2) ? key_ext[63:32] : key_ext[31:0];
  assign mul_b   = (step_q == 4'd1) ? HASH_MULT[63:32] : HASH_MULT[31:0];
  assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};

  // Four restoring remainder steps on the top nibble of the hash word.
  always_comb begin : rem_step
    logic [REM_W-1:0] r;
    r = REM_W'(rem_q);
    for (int j = 0; j < 4; j++) begin
      r = {r[SLOT_W-1:0], acc_q[31-j]};
      if (r >= MOD_N) begin
        r = r - MOD_N;
      end
    end
    rem_next = r[SLOT_W-1:0];
  end

  // Sequencer next state: steps 0 to 3 multiply, steps 4 to 11 reduce.
  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) state_d = H_MUL;
      end
      H_MUL: begin
        if (step_q == 4'd3) state_d = H_MOD;
      end
      H_MOD: begin
        if (step_q == 4'd11) state_d = H_DONE;
      end
      H_DONE:  state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      if (state_q == H_IDLE) begin
        step_q <= 4'd0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Datapath: product accumulation, then the remainder sweep.
  always_ff @(posedge clk_i) begin
    case (state_q)
      H_MUL: begin
        prod_q <= mul_p;
        case (step_q)
          4'd1:    acc_q <= prod_q[63:32];
          4'd2:    acc_q <= acc_q + prod_q[31:0];
          4'd3: begin
            acc_q <= acc_q + prod_q[31:0];
            rem_q <= '0;
          end
          default: acc_q <= acc_q;
        endcase
      end
      H_MOD: begin
        rem_q <= rem_next;
        acc_q <= {acc_q[27:0], 4'd0};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign stat_o.busy = (state_q != H_IDLE);
  assign stat_o.done = (state_q == H_DONE);
  assign slot_o      = rem_q;

endmodule

/* src/kmer_pair_last_seen_map.sv */
// ----------------------------------------------------------------------------
// kmer_pair_last_seen_map: last-seen read id per k-mer pair
// Collects two k-mers per read and maps the pair to the id of the read that
// last carried it, in a hashed table with bounded linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   takes one request per cycle when idle: a base to push, or a clear.
//   out_if  gives one result for each pushed base flagged as last.
//   cfg_if  writes first_block and second_block; it is always ready and is
//           to be written only while the block is idle; no check enforces it.
// Lookup sequence:
//   A short read gives its result in the cycle after it is accepted. A long
//   read passes through the slot hash unit (start, four multiply steps, eight
//   remainder steps, done), then the read and evaluate states on the table
//   memory for each probe, at most PROBE_LIMIT probes, then the emit state
//   that issues the result. No request is taken while a lookup runs; input
//   is ready again in the cycle when the receiver takes the result.
// Reset and clear:
//   After reset, and after every clear request, a sweep writes every table
//   entry invalid, one per cycle; no request is accepted during the sweep.
// Stalls:
//   One output register holds a result; while it is full and not taken, no
//   request is accepted and a finished lookup waits.
// ----------------------------------------------------------------------------
module kmer_pair_last_seen_map #(
  parameter int KMER_LEN      = 8,
  parameter int TABLE_ENTRIES = 4096,
  parameter int PROBE_LIMIT   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kpls_stream_if.sink   in_if,
  kpls_stream_if.source out_if,
  kpls_stream_if.sink   cfg_if
);
  import kpls_pkg::*;

  localparam int KEY_W   = 2 * KMER_LEN;
  localparam int COMBO_W = 2 * KEY_W;
  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int MEM_W   = 1 + COMBO_W + ID_W;
  localparam int SPAN_W  = BLOCK_W + $clog2(KMER_LEN) + 1;
  localparam int PCNT_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [BLOCK_W-1:0]  first_block_q, second_block_q;
  logic [COUNT_W-1:0]  count_q;
  logic [KEY_W-1:0]    first_key_q, second_key_q;
  logic [COMBO_W-1:0]  combo_q;
  logic [ID_W-1:0]     rid_q;
  logic                hash_start_q;
  logic [SLOT_W-1:0]   slot_q, clr_addr_q, hash_slot;
  logic [PCNT_W-1:0]   probe_cnt_q;
  logic                out_valid_q;
  kpls_out_t           out_q, res_q;
  kpls_hash_stat_t     hash_stat;

  logic                in_acc, push_acc, clear_acc, end_acc, out_free, out_load;
  logic [SPAN_W-1:0]   pos_ext, s1, s2, need;
  logic                in_w1, in_w2, is_short;
  logic [COUNT_W-1:0]  count_upd;
  logic [KEY_W-1:0]    first_key_upd, second_key_upd;

  logic [MEM_W-1:0]    table_mem [TABLE_ENTRIES];
  logic [MEM_W-1:0]    rdata_q;
  logic                mem_we, mem_re;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [MEM_W-1:0]    mem_wdata;
  logic                ent_valid, hit, empty, last_probe;
  logic [COMBO_W-1:0]  ent_key;
  logic [ID_W-1:0]     ent_id;
  logic [SLOT_W-1:0]   slot_inc;

  // Handshakes.
  assign out_free     = !out_valid_q || out_if.ready;
  assign in_if.ready  = (state_q == S_IDLE) && out_free;
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign push_acc     = in_acc && (in_if.payload.operation == OP_PUSH);
  assign clear_acc    = in_acc && (in_if.payload.operation == OP_CLEAR);
  assign end_acc      = push_acc && in_if.payload.last;

  // The result register loads a short read at once, a lookup when it issues.
  assign out_load = (end_acc && is_short) || ((state_q == S_EMIT) && out_free);

  // Window tests for the two k-mers and the read length check.
  assign pos_ext   = SPAN_W'(count_q);
  assign s1        = SPAN_W'(first_block_q) * SPAN_W'(KMER_LEN);
  assign s2        = SPAN_W'(second_block_q) * SPAN_W'(KMER_LEN);
  assign in_w1     = (count_q != COUNT_MAX) && (pos_ext >= s1) &&
                     (pos_ext < s1 + SPAN_W'(KMER_LEN));
  assign in_w2     = (count_q != COUNT_MAX) && (pos_ext >= s2) &&
                     (pos_ext < s2 + SPAN_W'(KMER_LEN));
  assign count_upd = (count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;
  assign need      = (SPAN_W'(second_block_q) + SPAN_W'(1)) * SPAN_W'(KMER_LEN);
  assign is_short  = (need > SPAN_W'(COUNT_MAX)) || (SPAN_W'(count_upd) < need);

  assign first_key_upd  = in_w1 ? {first_key_q[KEY_W-BASE_W-1:0], in_if.payload.base}
                                : first_key_q;
  assign second_key_upd = in_w2 ? {second_key_q[KEY_W-BASE_W-1:0], in_if.payload.base}
                                : second_key_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_block_q  <= '0;
      second_block_q <= BLOCK_W'(1);
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.payload.index)
        REG_FIRST_BLOCK:  first_block_q  <= cfg_if.payload.data;
        REG_SECOND_BLOCK: second_block_q <= cfg_if.payload.data;
        default:          first_block_q  <= first_block_q;
      endcase
    end
  end

  // Read collection; everything returns to zero after the last base.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      first_key_q  <= '0;
      second_key_q <= '0;
    end else if (push_acc) begin
      if (in_if.payload.last) begin
        count_q      <= '0;
        first_key_q  <= '0;
        second_key_q <= '0;
      end else begin
        count_q      <= count_upd;
        first_key_q  <= first_key_upd;
        second_key_q <= second_key_upd;
      end
    end
  end

  // Slot hash unit.
  kpls_slot_hash #(
    .COMBO_W       (COMBO_W),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .key_i   (combo_q),
    .stat_o  (hash_stat),
    .slot_o  (hash_slot)
  );

  // Entry fields of the word read at the current probe slot.
  assign ent_valid  = rdata_q[MEM_W-1];
  assign ent_key    = rdata_q[ID_W +: COMBO_W];
  assign ent_id     = rdata_q[ID_W-1:0];
  assign empty      = !ent_valid;
  assign hit        = ent_valid && (ent_key == combo_q);
  assign last_probe = (probe_cnt_q == PCNT_W'(PROBE_LIMIT - 1));
  assign slot_inc   = (slot_q == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + SLOT_W'(1);

  // Memory ports: probe read, clear sweep, or write-back of a hit or insert.
  assign mem_re    = (state_q == S_READ);
  assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_EVAL) && (empty || hit));
  assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : slot_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, combo_q, rid_q};

  // Table memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= table_mem[slot_q];
    end
  end

  // Controller next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == SLOT_W'(TABLE_ENTRIES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (clear_acc) begin
          state_d = S_CLEAR;
        end else if (end_acc && !is_short) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_stat.done) state_d = S_READ;
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (empty || hit || last_probe) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      hash_start_q <= 1'b0;
      probe_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hash_start_q <= end_acc && !is_short;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + SLOT_W'(1);
        end
        S_IDLE: begin
          clr_addr_q <= '0;
        end
        S_HASH: begin
          probe_cnt_q <= '0;
        end
        S_EVAL: begin
          if (!(empty || hit || last_probe)) begin
            probe_cnt_q <= probe_cnt_q + PCNT_W'(1);
          end
        end
        default: begin
          clr_addr_q <= '0;
        end
      endcase
    end
  end

  // Lookup payload registers.
  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      combo_q <= {first_key_upd, second_key_upd};
      rid_q   <= in_if.payload.read_id;
    end
    if (end_acc && is_short) begin
      out_q.link_id <= in_if.payload.read_id;
      out_q.status  <= STATUS_SHORT;
    end
    if ((state_q == S_EMIT) && out_free) begin
      out_q <= res_q;
    end
    if ((state_q == S_HASH) && hash_stat.done) begin
      slot_q <= hash_slot;
    end
    if (state_q == S_EVAL) begin
      slot_q <= slot_inc;
      if (empty) begin
        res_q.link_id <= rid_q;
        res_q.status  <= STATUS_FIRST;
      end else if (hit) begin
        res_q.link_id <= ent_id;
        res_q.status  <= STATUS_SEEN;
      end else begin
        res_q.link_id <= rid_q;
        res_q.status  <= STATUS_FULL;
      end
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

`ifndef SYNTHESIS
  // The hash unit reports completion only while the controller waits for it.
  a_hash_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_stat.done |-> (state_q == S_HASH))
    else $error("hash done outside of hash wait");

  // A new hash is started only when the unit is free.
  a_hash_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_start_q |-> !hash_stat.busy)
    else $error("hash started while busy");

  // Probing never goes beyond the probe limit.
  a_probe_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (probe_cnt_q <= PCNT_W'(PROBE_LIMIT - 1)))
    else $error("probe count beyond limit");

  // A clear request starts the sweep at the first entry.
  a_clear_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_acc |=> ((state_q == S_CLEAR) && (clr_addr_q == '0)))
    else $error("clear sweep not started");

  // A table write-back during a lookup always ends the probe sequence.
  a_write_ends_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_EVAL)) |=> (state_q == S_EMIT))
    else $error("write-back did not end the lookup");
`endif

endmodule

/* tb/sv/tb_kmer_pair_last_seen_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_pair_last_seen_map: self-checking bench for the k-mer pair map
// Streams reads and table clears into the map under several block settings.
// A behavioral copy of the hashed table predicts link id and status for every
// read end, and each result is checked in order, with random idling on both
// channels and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_kmer_pair_last_seen_map;
  import kpls_pkg::*;

  localparam int KMER_LEN       = 8;
  localparam int TABLE_ENTRIES  = 4096;
  localparam int PROBE_LIMIT    = 8;
  localparam int KEY_W          = 2 * KMER_LEN;
  // A clear sweep of the table is the slowest thing the block does.
  localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 200;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TAIL_CYCLES    = 100;

  logic clk_i = 1'b0;
  logic rst_ni;

  kpls_stream_if #(.payload_t(kpls_in_t))  in_ch ();
  kpls_stream_if #(.payload_t(kpls_out_t)) out_ch ();
  kpls_stream_if #(.payload_t(kpls_cfg_t)) cfg_ch ();

  kmer_pair_last_seen_map #(
    .KMER_LEN      (KMER_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PROBE_LIMIT   (PROBE_LIMIT)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the block: settings, read being collected and the table.
  logic [BLOCK_W-1:0] cfg_first;
  logic [BLOCK_W-1:0] cfg_second;
  int unsigned        bases_seen;
  logic [KEY_W-1:0]   first_kmer;
  logic [KEY_W-1:0]   second_kmer;
  logic [2*KEY_W-1:0] pair_store [TABLE_ENTRIES];
  logic [ID_W-1:0]    last_id_store [TABLE_ENTRIES];
  bit                 slot_taken [TABLE_ENTRIES];

  kpls_out_t          link_expect_q [$];
  kpls_in_t           base_feed_q [$];
  logic [KEY_W-1:0]   crowd_keys [$];
  logic [2*KEY_W-1:0] recent_pairs [$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_rx;
  bit holdoff_go;

  task automatic flag_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int unsigned home_slot(input logic [2*KEY_W-1:0] pair);
    logic [63:0] prod;
    prod = 64'(pair) * HASH_MULT;
    return prod[63:32] % TABLE_ENTRIES;
  endfunction

  // Advance the mirror by one accepted request and queue the result it causes.
  task automatic track_request(input kpls_in_t req);
    int unsigned        need;
    int unsigned        start1;
    int unsigned        start2;
    int unsigned        slot;
    logic [2*KEY_W-1:0] pair;
    kpls_out_t          res;
    if (req.operation == OP_CLEAR) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      return;
    end
    if (bases_seen < COUNT_MAX) begin
      start1 = cfg_first * KMER_LEN;
      start2 = cfg_second * KMER_LEN;
      if (bases_seen >= start1 && bases_seen < start1 + KMER_LEN) begin
        first_kmer = {first_kmer[KEY_W-3:0], req.base};
      end
      if (bases_seen >= start2 && bases_seen < start2 + KMER_LEN) begin
        second_kmer = {second_kmer[KEY_W-3:0], req.base};
      end
      bases_seen++;
    end
    if (!req.last) return;
    need = (cfg_second + 1) * KMER_LEN;
    res.link_id = req.read_id;
    res.status  = STATUS_SHORT;
    if (need <= COUNT_MAX && bases_seen >= need) begin
      pair = {first_kmer, second_kmer};
      slot = home_slot(pair);
      res.status = STATUS_FULL;
      // Bounded linear probe with wrap-around.
      for (int p = 0; p < PROBE_LIMIT; p++) begin
        if (!slot_taken[slot]) begin
          slot_taken[slot]    = 1'b1;
          pair_store[slot]    = pair;
          last_id_store[slot] = req.read_id;
          res.status          = STATUS_FIRST;
          break;
        end
        if (pair_store[slot] == pair) begin
          res.link_id         = last_id_store[slot];
          last_id_store[slot] = req.read_id;
          res.status          = STATUS_SEEN;
          break;
        end
        slot = (slot + 1) % TABLE_ENTRIES;
      end
    end
    bases_seen  = 0;
    first_kmer  = '0;
    second_kmer = '0;
    link_expect_q.push_back(res);
  endtask

  task automatic queue_clear();
    kpls_in_t req;
    req.operation = OP_CLEAR;
    req.read_id   = $urandom;
    req.base      = BASE_W'($urandom);
    req.last      = 1'($urandom);
    base_feed_q.push_back(req);
  endtask

  // Queue one read whose k-mer windows carry the given pair; a clear request
  // is slipped in before base clear_at when that lies inside the read.
  task automatic queue_read(input int unsigned len, input logic [2*KEY_W-1:0] pair,
                            input logic [ID_W-1:0] last_id, input int clear_at);
    int unsigned s1;
    int unsigned s2;
    kpls_in_t    req;
    s1 = cfg_first * KMER_LEN;
    s2 = cfg_second * KMER_LEN;
    for (int unsigned p = 0; p < len; p++) begin
      if (int'(p) == clear_at) queue_clear();
      req.operation = OP_PUSH;
      req.read_id   = $urandom;
      req.base      = BASE_W'($urandom);
      req.last      = (p == len - 1);
      if (p >= s2 && p < s2 + KMER_LEN) begin
        req.base = pair[2*(KMER_LEN-1-(p-s2)) +: 2];
      end
      if (p >= s1 && p < s1 + KMER_LEN) begin
        req.base = pair[KEY_W + 2*(KMER_LEN-1-(p-s1)) +: 2];
      end
      if (req.last) req.read_id = last_id;
      base_feed_q.push_back(req);
    end
  endtask

  // Mostly long enough reads whose keys repeat, crowd one slot or are random,
  // with short reads, clears and clears in the middle of a read mixed in.
  task automatic queue_random_reads(input int unsigned items, input int unsigned extra);
    int unsigned        need;
    int unsigned        len;
    int unsigned        pick;
    int unsigned        queued;
    int                 clear_at;
    logic [KEY_W-1:0]   k;
    logic [2*KEY_W-1:0] pair;
    need   = (cfg_second + 1) * KMER_LEN;
    queued = 0;
    while (queued < items) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        queue_clear();
        queued++;
        continue;
      end
      if (pick < 22 || need > COUNT_MAX) begin
        len = $urandom_range((need > 41) ? 40 : need - 1, 1);
      end else begin
        len = need + $urandom_range(extra, 0);
      end
      clear_at = ($urandom_range(99) < 5) ? int'($urandom_range(len - 1, 0)) : -1;
      pick = $urandom_range(9);
      if (pick < 4 && recent_pairs.size() > 0) begin
        pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
      end else if (pick < 6) begin
        k    = crowd_keys[$urandom_range(crowd_keys.size() - 1)];
        pair = {k, k};
      end else begin
        pair = $urandom;
      end
      if (cfg_first == cfg_second) pair[KEY_W-1:0] = pair[2*KEY_W-1:KEY_W];
      recent_pairs.push_back(pair);
      if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
      queue_read(len, pair, $urandom, clear_at);
      queued += len;
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic write_block_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [BLOCK_W-1:0] val);
    @(posedge clk_i);
    cfg_ch.payload <= kpls_cfg_t'{index: idx, data: val};
    cfg_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FIRST_BLOCK) begin
      cfg_first = val;
    end else begin
      cfg_second = val;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (base_feed_q.size() != 0 || in_ch.valid || link_expect_q.size() != 0);
  endtask

  // Settings change only once every result is back and the block is quiet.
  task automatic enter_phase(input logic [BLOCK_W-1:0] fb, input logic [BLOCK_W-1:0] sb);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_block_reg(REG_FIRST_BLOCK, fb);
    write_block_reg(REG_SECOND_BLOCK, sb);
  endtask

  // Request driver: holds a request until it is taken, then offers the next.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) track_request(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (base_feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.payload <= base_feed_q.pop_front();
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result with the oldest prediction.
  always @(posedge clk_i) begin
    kpls_out_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (link_expect_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result link_id=%h status=%0d",
                                  out_ch.payload.link_id, out_ch.payload.status));
        end else begin
          want = link_expect_q.pop_front();
          if (out_ch.payload.link_id !== want.link_id) begin
            flag_mismatch($sformatf("link_id %h, expected %h",
                                    out_ch.payload.link_id, want.link_id));
          end
          if (out_ch.payload.status !== want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d",
                                    out_ch.payload.status, want.status));
          end
        end
      end
      out_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output stall, so the result register fills and input backs up.
  initial begin
    hold_rx = 1'b0;
    wait (holdoff_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #(3_000_000 * 12);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                 target;
    int unsigned        s;
    int                 slot_hits [TABLE_ENTRIES];
    logic [KEY_W-1:0]   k;
    logic [2*KEY_W-1:0] pair;

    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    error_count    = 0;
    cfg_first      = '0;
    cfg_second     = BLOCK_W'(1);
    bases_seen     = 0;
    first_kmer     = '0;
    second_kmer    = '0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;

    // Find keys of the form {k,k} that all hash to one slot, one more than
    // the probe window holds, so the table can be driven full.
    target = -1;
    for (int i = 0; i < (1 << KEY_W) && target < 0; i++) begin
      s = home_slot({KEY_W'(i), KEY_W'(i)});
      slot_hits[s]++;
      if (slot_hits[s] == PROBE_LIMIT + 1) target = s;
    end
    for (int i = 0; i < (1 << KEY_W) && crowd_keys.size() < PROBE_LIMIT + 1; i++) begin
      if (home_slot({KEY_W'(i), KEY_W'(i)}) == target) crowd_keys.push_back(KEY_W'(i));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: clear, first insert, short read, a clear inside a read,
    // then a repeat of the same pair.
    set_idling(35, 88);
    queue_clear();
    queue_read(16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1);
    queue_read(1, 32'h0, 32'h0, -1);
    queue_read(16, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 5);
    queue_read(16, 32'hFFFF_FFFF, 32'h0, -1);

    // One block for both k-mers: fill the probe window, overflow it, then hit.
    enter_phase(BLOCK_W'(0), BLOCK_W'(0));
    queue_clear();
    foreach (crowd_keys[i]) queue_read(KMER_LEN, {crowd_keys[i], crowd_keys[i]}, $urandom, -1);
    queue_read(KMER_LEN, {crowd_keys[0], crowd_keys[0]}, $urandom, -1);
    queue_read(KMER_LEN, {crowd_keys[PROBE_LIMIT], crowd_keys[PROBE_LIMIT]}, $urandom, -1);
    queue_random_reads(150, 4);

    enter_phase(BLOCK_W'(0), BLOCK_W'(1));
    queue_random_reads(120, 8);

    // First block often beyond the read end: partial first k-mer.
    set_idling(88, 35);
    enter_phase(BLOCK_W'(5), BLOCK_W'(1));
    queue_random_reads(150, 34);

    enter_phase(BLOCK_W'(1), BLOCK_W'(0));
    queue_random_reads(150, 8);

    // Keys near the counter limit; the last read runs past saturation.
    set_idling(0, 0);
    enter_phase(BLOCK_W'(30), BLOCK_W'(30));
    k    = $urandom;
    pair = {k, k};
    queue_read(247, pair, $urandom, -1);
    queue_read(248, pair, $urandom, -1);
    queue_read(290, pair, $urandom, -1);

    // Length requirement above the counter range: every read is short.
    enter_phase(BLOCK_W'(63), BLOCK_W'(63));
    queue_random_reads(80, 0);

    enter_phase(BLOCK_W'(0), BLOCK_W'(1));
    holdoff_go = 1'b1;
    queue_random_reads(170, 4);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/kpls_pkg.sv
src/kpls_stream_if.sv
src/kpls_slot_hash.sv
src/kmer_pair_last_seen_map.sv
tb/sv/tb_kmer_pair_last_seen_map.sv
